/* sv/grc_pkg.sv */
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the grid column ray caster
// Item formats, register indexes, status codes, colors and datapath widths.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAX_MAP_SIDE_DEF    = 64;
  localparam int MAX_SCREEN_SIDE_DEF = 1024;

  // Divider widths: the largest dividend is 2^28, the largest divisor a
  // side distance. A side distance grows by at most 2^40 per grid step and
  // stays below 2^50 for the largest map side.
  localparam int DIV_N   = 29;
  localparam int DIV_D   = 50;
  localparam int DELTA_W = 41;
  localparam int SD_W    = 50;

  localparam logic [DELTA_W-1:0] DELTA_INF = DELTA_W'(1) << 40;
  localparam logic [31:0] COLOR_LIGHT = 32'hFF3CAA28;
  localparam logic [31:0] COLOR_DARK  = 32'hFF1E8C14;
  localparam logic [23:0] PERP_MAX    = 24'hFFFFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_LEFT    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [2:0] REG_MAP_W    = 3'd0;
  localparam logic [2:0] REG_MAP_H    = 3'd1;
  localparam logic [2:0] REG_SCR_W    = 3'd2;
  localparam logic [2:0] REG_SCR_H    = 3'd3;
  localparam logic [2:0] REG_PLAYER   = 3'd4;
  localparam logic [2:0] REG_VIEW_DIR = 3'd5;
  localparam logic [2:0] REG_PLANE    = 3'd6;

  typedef struct packed {
    logic        opcode;
    logic [11:0] cell_index;
    logic [7:0]  cell_value;
    logic [9:0]  column;
  } grc_in_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic [1:0]  status;
    logic        wall_side;
    logic [23:0] perp_distance;
    logic [9:0]  span_top;
    logic [9:0]  span_bottom;
    logic [31:0] color;
  } grc_out_t;

endpackage

/* sv/grc_div.sv */
// ----------------------------------------------------------------------------
// grc_div: shared restoring divider
// Unsigned quotient, one bit per cycle; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module grc_div #(
  parameter int N = grc_pkg::DIV_N,
  parameter int D = grc_pkg::DIV_D
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);
  localparam int CW = $clog2(N);

  logic         busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [N-1:0] quo_r;
  logic [D-1:0] rem_r, div_r, rem_nxt;
  logic [D:0]   trial;
  logic         qbit;

  always_comb begin
    trial = {rem_r, quo_r[N-1]};
    qbit  = trial >= {1'b0, div_r};
    if (qbit) begin
      rem_nxt = D'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[N-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/grid_raycast_column.sv */
// ----------------------------------------------------------------------------
// grid_raycast_column: DDA column ray caster over a wall grid
// Keeps a one-bit wall map and answers one screen column per cast item.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid/in_stall/in_data. A write item (opcode 0)
// stores one map cell and gives no result; a cast item (opcode 1) gives one
// result on out_valid/out_stall/out_data, unless its column is at or beyond
// the screen width. Registers must be written on the cfg port only while
// idle; the block itself does not enforce it. After reset the map is
// swept to air, one cell per cycle over all MAX_MAP_SIDE^2 cells (4096 by
// default); in_stall stays high during that pass. A write item is stored as
// it is accepted. A cast item runs the camera, two reciprocal and one height
// division in the shared bit-serial divider (a division is skipped when its
// divisor is zero), with setup and output states, and each DDA grid step
// passes the step, bound and check states (map read, registered), up to
// 2 * MAX_MAP_SIDE + 2 steps. A player outside the map goes from idle
// straight to the output state. The block takes one item at a time. A
// finished result waits in the output register while out_stall is high;
// the next item is still accepted, and its result waits for it.
// ----------------------------------------------------------------------------
module grid_raycast_column #(
  parameter int MAX_MAP_SIDE    = grc_pkg::MAX_MAP_SIDE_DEF,
  parameter int MAX_SCREEN_SIDE = grc_pkg::MAX_SCREEN_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  grc_pkg::grc_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output grc_pkg::grc_out_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);
  import grc_pkg::*;

  localparam int CELLS = MAX_MAP_SIDE * MAX_MAP_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(MAX_MAP_SIDE);
  localparam int MXW   = CW + 2;
  localparam int SMW   = $clog2(MAX_MAP_SIDE + 1);
  localparam int SSW   = $clog2(MAX_SCREEN_SIDE + 1);
  localparam int ITW   = $clog2(2 * MAX_MAP_SIDE + 3);
  localparam int LINE_MAX = 4 * MAX_SCREEN_SIDE;
  localparam int LW    = $clog2(LINE_MAX + 1);

  typedef enum logic [18:0] {
    S_CLEAR = 19'b0000000000000000001,
    S_IDLE  = 19'b0000000000000000010,
    S_CAM   = 19'b0000000000000000100,
    S_CAMW  = 19'b0000000000000001000,
    S_RAYX  = 19'b0000000000000010000,
    S_RAYY  = 19'b0000000000000100000,
    S_DX    = 19'b0000000000001000000,
    S_DXW   = 19'b0000000000010000000,
    S_DY    = 19'b0000000000100000000,
    S_DYW   = 19'b0000000001000000000,
    S_SDX   = 19'b0000000010000000000,
    S_SDY   = 19'b0000000100000000000,
    S_STEP  = 19'b0000001000000000000,
    S_BND   = 19'b0000010000000000000,
    S_CHK   = 19'b0000100000000000000,
    S_LINE  = 19'b0001000000000000000,
    S_LINEW = 19'b0010000000000000000,
    S_SPAN  = 19'b0100000000000000000,
    S_OUT   = 19'b1000000000000000000
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [6:0]  map_w_r, map_h_r;
  logic [10:0] scr_w_r, scr_h_r;
  logic [31:0] player_r, dir_r, plane_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r  <= 7'd64;
      map_h_r  <= 7'd64;
      scr_w_r  <= 11'd640;
      scr_h_r  <= 11'd480;
      player_r <= '0;
      dir_r    <= '0;
      plane_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_W:    map_w_r  <= cfg_wdata[6:0];
        REG_MAP_H:    map_h_r  <= cfg_wdata[6:0];
        REG_SCR_W:    scr_w_r  <= cfg_wdata[10:0];
        REG_SCR_H:    scr_h_r  <= cfg_wdata[10:0];
        REG_PLAYER:   player_r <= cfg_wdata;
        REG_VIEW_DIR: dir_r    <= cfg_wdata;
        REG_PLANE:    plane_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective sizes, clamped to their legal ranges.
  logic [SMW-1:0] mw, mh;
  logic [SSW-1:0] sw, sh;

  always_comb begin
    if (map_w_r == '0) mw = SMW'(1);
    else if (32'(map_w_r) > MAX_MAP_SIDE) mw = SMW'(MAX_MAP_SIDE);
    else mw = SMW'(map_w_r);
    if (map_h_r == '0) mh = SMW'(1);
    else if (32'(map_h_r) > MAX_MAP_SIDE) mh = SMW'(MAX_MAP_SIDE);
    else mh = SMW'(map_h_r);
    if (scr_w_r == '0) sw = SSW'(1);
    else if (32'(scr_w_r) > MAX_SCREEN_SIDE) sw = SSW'(MAX_SCREEN_SIDE);
    else sw = SSW'(scr_w_r);
    if (scr_h_r == '0) sh = SSW'(1);
    else if (32'(scr_h_r) > MAX_SCREEN_SIDE) sh = SSW'(MAX_SCREEN_SIDE);
    else sh = SSW'(scr_h_r);
  end

  logic [15:0] px, py;
  assign px = player_r[31:16];
  assign py = player_r[15:0];

  logic accept;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Datapath registers
  logic [9:0]               col_r;
  logic signed [15:0]       cam_r;
  logic signed [17:0]       rx_r, ry_r;
  logic [DELTA_W-1:0]       dx_r, dy_r;
  logic [SD_W-1:0]          sdx_r, sdy_r, perp_r;
  logic signed [MXW-1:0]    mx_r, my_r;
  logic [ITW-1:0]           iter_r;
  logic                     side_r;
  logic [1:0]               st_r;
  logic [LW-1:0]            line_r;
  logic [AW-1:0]            clr_r;
  logic                     rd_r;

  // Shared multiplier for the ray components.
  logic signed [15:0] mul_a;
  logic signed [31:0] mul_p;
  assign mul_a = (state_r == S_RAYX) ? $signed(plane_r[31:16]) : $signed(plane_r[15:0]);
  assign mul_p = mul_a * cam_r;

  // Shared multiplier for the initial side distances.
  logic [8:0]          frac_f;
  logic [DELTA_W-1:0]  sd_delta;
  logic [DELTA_W+8:0]  sd_prod;
  always_comb begin
    if (state_r == S_SDX) begin
      frac_f   = rx_r[17] ? {1'b0, px[7:0]} : 9'd256 - {1'b0, px[7:0]};
      sd_delta = dx_r;
    end else begin
      frac_f   = ry_r[17] ? {1'b0, py[7:0]} : 9'd256 - {1'b0, py[7:0]};
      sd_delta = dy_r;
    end
    sd_prod = frac_f * sd_delta;
  end

  // Divider operands
  logic             div_start, div_done;
  logic [DIV_N-1:0] div_a, div_q;
  logic [DIV_D-1:0] div_b;
  logic [16:0]      rx_abs, ry_abs;
  assign rx_abs = rx_r[17] ? 17'(-rx_r) : rx_r[16:0];
  assign ry_abs = ry_r[17] ? 17'(-ry_r) : ry_r[16:0];

  always_comb begin
    div_start = 1'b0;
    div_a     = DIV_N'(1) << 28;
    div_b     = DIV_D'(rx_abs);
    unique case (state_r)
      S_CAM: begin
        div_start = 1'b1;
        div_a     = DIV_N'(col_r) << 15;
        div_b     = DIV_D'(sw);
      end
      S_DX: div_start = (rx_r != '0);
      S_DY: begin
        div_start = (ry_r != '0);
        div_b     = DIV_D'(ry_abs);
      end
      S_LINE: begin
        div_start = (perp_r != '0);
        div_a     = DIV_N'(sh) << 14;
        div_b     = DIV_D'(perp_r);
      end
      default: ;
    endcase
  end

  grc_div #(.N(DIV_N), .D(DIV_D)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Map memory
  logic mem [CELLS];
  logic            mem_we, mem_wd;
  logic [AW-1:0]   mem_wa, rd_addr;
  logic            cell_ok;

  assign cell_ok = 32'(in_data.cell_index) < CELLS;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wd = 1'b0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && in_data.opcode == OP_WRITE && cell_ok) begin
      mem_we = 1'b1;
      mem_wa = AW'(in_data.cell_index);
      mem_wd = (in_data.cell_value != '0);
    end
  end

  assign rd_addr = AW'(my_r[CW-1:0]) * AW'(mw) + AW'(mx_r[CW-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state_r == S_BND) rd_r <= mem[rd_addr];
  end

  logic out_of_map;
  assign out_of_map = mx_r[MXW-1] || my_r[MXW-1] ||
                      mx_r >= $signed(MXW'(mw)) || my_r >= $signed(MXW'(mh));

  logic sx_lt;
  assign sx_lt = sdx_r < sdy_r;

  // Span arithmetic
  logic [LW-2:0]  half;
  logic [SSW-1:0] sh_half, span_start;
  logic [SSW:0]   span_end;
  always_comb begin
    half    = line_r[LW-1:1];
    sh_half = sh >> 1;
    if (32'(half) >= 32'(sh_half)) span_start = '0;
    else span_start = SSW'(32'(sh_half) - 32'(half));
    if (32'(sh_half) + 32'(half) >= 32'(sh)) span_end = (SSW+1)'(sh - 1'b1);
    else span_end = (SSW+1)'(32'(sh_half) + 32'(half));
  end

  logic     out_valid_r;
  grc_out_t out_r, out_nxt;
  logic [9:0] start_r, end_r;

  // A miss or a player outside the map carries only column and status.
  always_comb begin
    out_nxt            = '0;
    out_nxt.column_out = col_r;
    out_nxt.status     = st_r;
    if (st_r == ST_HIT) begin
      out_nxt.wall_side     = side_r;
      out_nxt.perp_distance = (perp_r > SD_W'(PERP_MAX)) ? PERP_MAX : perp_r[23:0];
      out_nxt.span_top      = start_r;
      out_nxt.span_bottom   = end_r;
      out_nxt.color         = side_r ? COLOR_DARK : COLOR_LIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(CELLS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && in_data.opcode == OP_CAST &&
              32'(in_data.column) < 32'(sw)) begin
            if (32'(px[15:8]) >= 32'(mw) || 32'(py[15:8]) >= 32'(mh)) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_CAM;
            end
          end
        end
        S_CAM:   state_r <= S_CAMW;
        S_CAMW:  if (div_done) state_r <= S_RAYX;
        S_RAYX:  state_r <= S_RAYY;
        S_RAYY:  state_r <= S_DX;
        S_DX:    state_r <= (rx_r != '0) ? S_DXW : S_DY;
        S_DXW:   if (div_done) state_r <= S_DY;
        S_DY:    state_r <= (ry_r != '0) ? S_DYW : S_SDX;
        S_DYW:   if (div_done) state_r <= S_SDX;
        S_SDX:   state_r <= S_SDY;
        S_SDY:   state_r <= S_STEP;
        S_STEP:  state_r <= S_BND;
        S_BND:   state_r <= out_of_map ? S_OUT : S_CHK;
        S_CHK: begin
          if (rd_r) state_r <= S_LINE;
          else if (iter_r == ITW'(2 * MAX_MAP_SIDE + 2)) state_r <= S_OUT;
          else state_r <= S_STEP;
        end
        S_LINE:  state_r <= (perp_r != '0) ? S_LINEW : S_SPAN;
        S_LINEW: if (div_done) state_r <= S_SPAN;
        S_SPAN:  state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || !out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath updates
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        col_r  <= in_data.column;
        st_r   <= ST_OUTSIDE;
        side_r <= 1'b0;
        perp_r <= '0;
        iter_r <= '0;
        mx_r   <= $signed(MXW'(px[15:8]));
        my_r   <= $signed(MXW'(py[15:8]));
      end
      S_CAMW: if (div_done) cam_r <= $signed({1'b0, div_q[14:0]}) - 16'sd16384;
      S_RAYX: rx_r <= 18'($signed(dir_r[31:16])) + mul_p[31:14];
      S_RAYY: ry_r <= 18'($signed(dir_r[15:0])) + mul_p[31:14];
      S_DX:   if (rx_r == '0) dx_r <= DELTA_INF;
      S_DXW:  if (div_done) dx_r <= DELTA_W'(div_q);
      S_DY:   if (ry_r == '0) dy_r <= DELTA_INF;
      S_DYW:  if (div_done) dy_r <= DELTA_W'(div_q);
      S_SDX:  sdx_r <= SD_W'(sd_prod >> 8);
      S_SDY:  sdy_r <= SD_W'(sd_prod >> 8);
      S_STEP: begin
        iter_r <= iter_r + 1'b1;
        st_r   <= ST_LEFT;
        if (sx_lt) begin
          perp_r <= sdx_r;
          sdx_r  <= sdx_r + SD_W'(dx_r);
          mx_r   <= rx_r[17] ? mx_r - 1'b1 : mx_r + 1'b1;
          side_r <= 1'b0;
        end else begin
          perp_r <= sdy_r;
          sdy_r  <= sdy_r + SD_W'(dy_r);
          my_r   <= ry_r[17] ? my_r - 1'b1 : my_r + 1'b1;
          side_r <= 1'b1;
        end
      end
      S_CHK:   if (rd_r) st_r <= ST_HIT;
      S_LINE:  if (perp_r == '0) line_r <= LW'(LINE_MAX);
      S_LINEW: begin
        if (div_done) begin
          line_r <= (32'(div_q) > LINE_MAX) ? LW'(LINE_MAX) : LW'(div_q);
        end
      end
      S_SPAN: begin
        start_r <= 10'(span_start);
        end_r   <= 10'(span_end);
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) out_r <= out_nxt;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == S_IDLE) else $error("item accepted while busy");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_CAMW || state_r == S_DXW ||
                  state_r == S_DYW || state_r == S_LINEW))
    else $error("divider finished outside a wait state");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_HIT |->
      out_data.color == '0 && out_data.perp_distance == '0)
    else $error("miss result carries wall fields");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall) else $error("input open during clear");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the grid column ray caster
// Loads wall maps, casts columns under several camera and size settings, and
// checks every result against a fixed-point DDA predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import grc_pkg::*;

  localparam int MAP_SIDE  = 64;
  localparam int SCR_SIDE  = 1024;
  localparam int CELLS     = MAP_SIDE * MAP_SIDE;
  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE    = 1200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  grc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  grc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  grid_raycast_column uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bench copy of the block state.
  bit        wall_map[CELLS];
  bit [6:0]  map_w_q, map_h_q;
  bit [10:0] scr_w_q, scr_h_q;
  bit [31:0] player_q, dir_q, plane_q;

  grc_out_t  pending_cols[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        stall_idle = 1'b1;   // 0 turns off random idling and random stalls
  bit        hold_off = 1'b0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint floor14(longint v);
    if (v >= 0) return v / 16384;
    return -((-v + 16383) / 16384);
  endfunction

  function automatic longint unsigned ray_delta(longint r);
    longint unsigned m;
    if (r == 0) return 64'd1 << 40;
    m = (r < 0) ? -r : r;
    return (64'd1 << 28) / m;
  endfunction

  function automatic longint unsigned first_side(longint r, bit [15:0] p,
                                                 longint unsigned d);
    longint unsigned f;
    f = 64'(p[7:0]);
    if (r >= 0) f = 256 - f;
    return (f * d) >> 8;
  endfunction

  // Applies one item to the bench state; returns 1 when a result is due.
  function automatic bit cast_column(grc_in_t it, output grc_out_t res);
    int unsigned mw, mh, sw, sh, start_r, end_r, half_l;
    longint cam, rx, ry;
    longint unsigned dx, dy, sdx, sdy, perp, line_h;
    int mx, my, stx, sty;
    bit side, hit;
    mw = clamp_size(map_w_q, MAP_SIDE);
    mh = clamp_size(map_h_q, MAP_SIDE);
    sw = clamp_size(scr_w_q, SCR_SIDE);
    sh = clamp_size(scr_h_q, SCR_SIDE);
    res = '0;
    if (it.opcode == OP_WRITE) begin
      wall_map[it.cell_index] = (it.cell_value != 0);
      return 1'b0;
    end
    if (it.column >= sw) return 1'b0;
    res.column_out = it.column;
    mx = int'(player_q[31:24]);
    my = int'(player_q[15:8]);
    if (mx >= mw || my >= mh) begin
      res.status = ST_OUTSIDE;
      return 1'b1;
    end
    cam = longint'((longint'(it.column) * 32768) / sw) - 16384;
    rx = longint'($signed(dir_q[31:16])) + floor14(longint'($signed(plane_q[31:16])) * cam);
    ry = longint'($signed(dir_q[15:0])) + floor14(longint'($signed(plane_q[15:0])) * cam);
    dx = ray_delta(rx);
    dy = ray_delta(ry);
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    sdx = first_side(rx, player_q[31:16], dx);
    sdy = first_side(ry, player_q[15:0], dy);
    perp = 0;
    side = 0;
    hit = 0;
    for (int s = 0; s < 2 * MAP_SIDE + 2; s++) begin
      if (sdx < sdy) begin
        perp = sdx; sdx += dx; mx += stx; side = 0;
      end else begin
        perp = sdy; sdy += dy; my += sty; side = 1;
      end
      if (mx < 0 || my < 0 || mx >= mw || my >= mh) break;
      if (wall_map[my * mw + mx]) begin
        hit = 1;
        break;
      end
    end
    if (!hit) begin
      res.status = ST_LEFT;
      return 1'b1;
    end
    if (perp == 0) line_h = 64'(4 * SCR_SIDE);
    else begin
      line_h = (64'(sh) << 14) / perp;
      if (line_h > 4 * SCR_SIDE) line_h = 64'(4 * SCR_SIDE);
    end
    half_l = 32'(line_h / 2);
    start_r = (half_l >= sh / 2) ? 0 : sh / 2 - half_l;
    end_r = sh / 2 + half_l;
    if (end_r >= sh) end_r = sh - 1;
    res.status = ST_HIT;
    res.wall_side = side;
    res.perp_distance = (perp > PERP_MAX) ? PERP_MAX : perp[23:0];
    res.span_top = start_r[9:0];
    res.span_bottom = end_r[9:0];
    res.color = side ? COLOR_DARK : COLOR_LIGHT;
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MAP_W:    map_w_q = val[6:0];
      REG_MAP_H:    map_h_q = val[6:0];
      REG_SCR_W:    scr_w_q = val[10:0];
      REG_SCR_H:    scr_h_q = val[10:0];
      REG_PLAYER:   player_q = val;
      REG_VIEW_DIR: dir_q = val;
      default:      plane_q = val;
    endcase
  endtask

  // Offers one item and waits for its acceptance.
  task automatic send_item(input grc_in_t it);
    grc_out_t res;
    while (stall_idle && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cast_column(it, res)) pending_cols.push_back(res);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cols.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic grc_in_t wr_item(int unsigned idx, int unsigned val);
    grc_in_t it;
    it = '0;
    it.opcode = OP_WRITE; it.cell_index = 12'(idx); it.cell_value = 8'(val);
    return it;
  endfunction

  function automatic grc_in_t cast_item(int unsigned col);
    grc_in_t it;
    it = '0;
    it.opcode = OP_CAST; it.column = 10'(col);
    return it;
  endfunction

  // Random item: mostly casts, sometimes walls, noise in unused fields.
  function automatic grc_in_t rand_item(int unsigned mw, int unsigned mh, int unsigned sw);
    grc_in_t it;
    it = grc_in_t'(31'($urandom));
    if ($urandom_range(99) < 35) begin
      it.opcode = OP_WRITE;
      if ($urandom_range(9) != 0)
        it.cell_index = 12'($urandom_range(mh - 1) * mw + $urandom_range(mw - 1));
      if ($urandom_range(3) == 0) it.cell_value = 0;
    end else begin
      it.opcode = OP_CAST;
      if ($urandom_range(19) != 0) it.column = 10'($urandom_range(sw - 1));
    end
    return it;
  endfunction

  // Directed table: op, index, value, column, check, expected result.
  typedef struct {
    grc_in_t  it;
    bit       typed;
    grc_out_t res;
  } dir_row_t;
  grc_out_t typed_q[$];
  bit       typed_flag[$];

  // Result checker.
  always @(posedge clk) begin
    grc_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cols.size() == 0) begin
        $error("result with nothing expected: column %0d", out_data.column_out);
        errors++;
      end else begin
        exp_r = pending_cols.pop_front();
        if (typed_flag.size() != 0) begin
          if (typed_flag.pop_front()) begin
            grc_out_t t;
            t = typed_q.pop_front();
            if (t != exp_r) begin
              $error("typed row disagrees with predictor: %h vs %h", t, exp_r);
              errors++;
            end
          end
        end
        if (out_data.column_out !== exp_r.column_out) begin
          $error("column_out exp %0d got %0d", exp_r.column_out, out_data.column_out); errors++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_data.status); errors++;
        end
        if (out_data.wall_side !== exp_r.wall_side) begin
          $error("wall_side exp %0d got %0d", exp_r.wall_side, out_data.wall_side); errors++;
        end
        if (out_data.perp_distance !== exp_r.perp_distance) begin
          $error("perp_distance exp %h got %h", exp_r.perp_distance, out_data.perp_distance);
          errors++;
        end
        if (out_data.span_top !== exp_r.span_top) begin
          $error("span_top exp %0d got %0d", exp_r.span_top, out_data.span_top); errors++;
        end
        if (out_data.span_bottom !== exp_r.span_bottom) begin
          $error("span_bottom exp %0d got %0d", exp_r.span_bottom, out_data.span_bottom);
          errors++;
        end
        if (out_data.color !== exp_r.color) begin
          $error("color exp %h got %h", exp_r.color, out_data.color); errors++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off on request.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stall_idle) out_stall <= ($urandom_range(99) < 29);
    else out_stall <= 1'b0;
  end

  // Watchdog on cycles without any accepted item or taken result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    grc_out_t z;
    int unsigned mw, mh, sw, sc;
    map_w_q = 64; map_h_q = 64; scr_w_q = 640; scr_h_q = 480;
    player_q = 0; dir_q = 0; plane_q = 0;
    foreach (wall_map[i]) wall_map[i] = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // After reset the player sits in cell 0,0 of an empty map; a ray with
    // zero direction alternates x and y steps and leaves the map.
    z = '0;
    r.typed = 1; r.it = cast_item(0); r.res = z; r.res.status = ST_LEFT; rows.push_back(r);
    r.it = cast_item(639); r.res.column_out = 639; rows.push_back(r);
    r.typed = 0;
    r.it = cast_item(640); rows.push_back(r);            // beyond screen: no result
    r.it = cast_item(1023); rows.push_back(r);
    r.it = wr_item(4095, 255); rows.push_back(r);
    r.it = wr_item(1, 1); rows.push_back(r);
    r.it = wr_item(64, 128); rows.push_back(r);
    r.it = cast_item(0); rows.push_back(r);
    r.it = cast_item(320); rows.push_back(r);
    r.it = wr_item(1, 0); rows.push_back(r);
    r.it = cast_item(1); rows.push_back(r);
    foreach (rows[k]) begin
      grc_in_t it;
      it = rows[k].it;
      if (it.opcode == OP_CAST && it.column < 640) begin
        typed_flag.push_back(rows[k].typed);
        if (rows[k].typed) typed_q.push_back(rows[k].res);
      end
      send_item(it);
    end
    drain_results();

    // Phase settings: extremes first, then random geometry.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin mw = 1; mh = 1; sw = 1; end
        1: begin mw = 64; mh = 64; sw = 1024; end
        2: begin mw = 0; mh = 127; sw = 0; end
        3: begin mw = 127; mh = 0; sw = 2047; end
        default: begin
          mw = $urandom_range(3, 16); mh = $urandom_range(3, 16);
          sw = $urandom_range(1, 1024);
        end
      endcase
      write_reg(REG_MAP_W, mw);
      write_reg(REG_MAP_H, mh);
      write_reg(REG_SCR_W, sw);
      case (ph)
        0: write_reg(REG_SCR_H, 1);
        1: write_reg(REG_SCR_H, 1024);
        2: write_reg(REG_SCR_H, 0);
        3: write_reg(REG_SCR_H, 2047);
        default: write_reg(REG_SCR_H, $urandom_range(1, 1024));
      endcase
      case (ph)
        0: write_reg(REG_PLAYER, 32'h0000_0000);
        1: write_reg(REG_PLAYER, 32'hFFFF_FFFF);          // outside the map
        2: write_reg(REG_PLAYER, 32'h0080_0080);
        3: write_reg(REG_PLAYER, 32'h00FF_0000);
        default: write_reg(REG_PLAYER,
          {8'($urandom_range(clamp_size(mw, 64) - 1)), 8'($urandom),
           8'($urandom_range(clamp_size(mh, 64) - 1)), 8'($urandom)});
      endcase
      write_reg(REG_VIEW_DIR, (ph == 1) ? 32'h8000_7FFF : $urandom);
      write_reg(REG_PLANE, (ph == 1) ? 32'h7FFF_8000 : $urandom);
      mw = clamp_size(map_w_q, 64); mh = clamp_size(map_h_q, 64);
      sc = clamp_size(scr_w_q, 1024);
      stall_idle = (ph != 6);
      for (int n = 0; n < 100; n++) begin
        if (ph == 8 && n == 30) hold_off = 1'b1;
        send_item(rand_item(mw, mh, sc));
        if (ph == 9 && n == 50) begin
          // Sender waits for every result before going on.
          in_valid <= 1'b0;
          while (pending_cols.size() != 0) @(negedge clk);
        end
      end
      drain_results();
    end
    stall_idle = 1'b1;
    in_valid <= 1'b0;
    drain_results();
    if (errors == 0 && pending_cols.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Long receiver hold-off, counted here.
  initial begin
    wait (hold_off);
    repeat (3000) @(negedge clk);
    hold_off = 1'b0;
  end

endmodule

/* sim.f */
sv/grc_pkg.sv
sv/grc_div.sv
sv/grid_raycast_column.sv
tb/tb_top.sv
